/* rtl/dmps_pkg.sv */
// Package for the door motor phase sequencer.
// Holds event kinds, command bytes, register indexes, reset values and shared structs.
// No dependencies; every other RTL file refers to it by scoped names.
`default_nettype none

package dmps_pkg;

  // Default width of the phase, saved and safety counters.
  localparam int COUNT_WIDTH_DEF = 16;

  // Configuration port geometry.
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 10;

  // Stream payload widths; the tdata widths are padded to whole bytes.
  localparam int IN_TDATA_WIDTH  = 16;
  localparam int IN_TUSER_WIDTH  = 2;
  localparam int OUT_TDATA_WIDTH = 16;

  // Event kinds carried in tuser.
  typedef enum logic [1:0] {
    KIND_PHASE_TICK  = 2'd0,
    KIND_SAFETY_TICK = 2'd1,
    KIND_SAFETY_TRIG = 2'd2,
    KIND_COMMAND     = 2'd3
  } kind_t;

  // Command bytes: ASCII '1' and '0'.
  localparam logic [7:0] CMD_RUN  = 8'h31;
  localparam logic [7:0] CMD_HALT = 8'h30;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    REG_FAST_DUTY        = 3'd0,
    REG_SLOW_DUTY        = 3'd1,
    REG_FAST_OPEN_END    = 3'd2,
    REG_SLOW_OPEN_END    = 3'd3,
    REG_STOP_START       = 3'd4,
    REG_CLOSE_START      = 3'd5,
    REG_SLOW_CLOSE_START = 3'd6,
    REG_SLOW_CLOSE_END   = 3'd7
  } reg_idx_t;

  // Register reset values.
  localparam logic [7:0] FAST_DUTY_RST        = 8'd10;
  localparam logic [7:0] SLOW_DUTY_RST        = 8'd5;
  localparam logic [9:0] FAST_OPEN_END_RST    = 10'd80;
  localparam logic [9:0] SLOW_OPEN_END_RST    = 10'd153;
  localparam logic [9:0] STOP_START_RST       = 10'd140;
  localparam logic [9:0] CLOSE_START_RST      = 10'd255;
  localparam logic [9:0] SLOW_CLOSE_START_RST = 10'd336;
  localparam logic [9:0] SLOW_CLOSE_END_RST   = 10'd408;

  // Current configuration as seen by the update logic.
  typedef struct packed {
    logic [7:0] fast_duty;
    logic [7:0] slow_duty;
    logic [9:0] fast_open_end;
    logic [9:0] slow_open_end;
    logic [9:0] stop_start;
    logic [9:0] close_start;
    logic [9:0] slow_close_start;
    logic [9:0] slow_close_end;
  } cfg_t;

  // Control flags and motor drive state (the counters travel separately).
  typedef struct packed {
    logic       run_enable;
    logic       safety_mode;
    logic       open_mark;
    logic       close_mark;
    logic       left_flag;
    logic       right_flag;
    logic       safety_timer_on;
    logic       direction;
    logic [7:0] duty;
    logic       indicator;
  } flags_t;

  // One decoded input event.
  typedef struct packed {
    kind_t      kind;
    logic       left_limit_active;
    logic       right_limit_active;
    logic [7:0] rx_byte;
  } event_t;

endpackage

`default_nettype wire

/* rtl/door_motor_phase_sequencer.sv */
// Top level of the door motor phase sequencer: stream ports, input and result registers.
// Depends on dmps_pkg, dmps_cfg_regs and dmps_step.
//
//   channel   | direction | payload
//   ----------+-----------+------------------------------------------------------
//   s_axis    | in        | tuser: kind; tdata: limits and received byte
//   m_axis    | out       | tdata: direction, duty, indicator, marks, safety flag
//   cfg       | in        | write enable, register index, write data
//
// Every event yields exactly one result transaction, and one event is taken per cycle
// unless the output stalls with both registers full. An accepted event is held in the
// input register; the state update and the result register load happen together when
// that register drains, and tvalid rises with the result register load.
// The input register drains whenever the result register is empty or being taken,
// so a stall on m_axis backs up into s_axis only when both registers are full.
// rst is synchronous and clears the state, the counters and both valid bits.
`default_nettype none

module door_motor_phase_sequencer #(
  parameter int COUNT_WIDTH = dmps_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Event input.
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [0] left_limit_active, [1] right_limit_active, [9:2] rx_byte, [15:10] zero
  input  wire logic [dmps_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,
  // [1:0] kind
  input  wire logic [dmps_pkg::IN_TUSER_WIDTH-1:0]  s_axis_tuser,
  // Result output.
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [0] motor_direction, [8:1] motor_duty, [9] indicator, [10] opening,
  // [11] closing, [12] safety_active, [15:13] zero
  output logic [dmps_pkg::OUT_TDATA_WIDTH-1:0]      m_axis_tdata,
  // Configuration writes.
  input  wire logic                                 cfg_wen,
  input  wire logic [dmps_pkg::CFG_IDX_WIDTH-1:0]   cfg_addr,
  input  wire logic [dmps_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);

  dmps_pkg::cfg_t         cfg;
  dmps_pkg::event_t       evt;
  logic                   evt_valid;
  logic                   advance;
  dmps_pkg::flags_t       flags;
  dmps_pkg::flags_t       flags_next;
  logic [COUNT_WIDTH-1:0] phase_count;
  logic [COUNT_WIDTH-1:0] phase_count_next;
  logic [COUNT_WIDTH-1:0] saved_count;
  logic [COUNT_WIDTH-1:0] saved_count_next;
  logic [COUNT_WIDTH-1:0] safety_count;
  logic [COUNT_WIDTH-1:0] safety_count_next;

  // Configuration registers.
  dmps_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The input register moves on whenever the result register has room.
  assign advance       = evt_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !evt_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (s_axis_tready) begin
      evt_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      evt.kind               <= dmps_pkg::kind_t'(s_axis_tuser);
      evt.left_limit_active  <= s_axis_tdata[0];
      evt.right_limit_active <= s_axis_tdata[1];
      evt.rx_byte            <= s_axis_tdata[9:2];
    end
  end

  // Event application.
  dmps_step #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .cfg               (cfg),
    .evt               (evt),
    .flags             (flags),
    .phase_count       (phase_count),
    .saved_count       (saved_count),
    .safety_count      (safety_count),
    .flags_next        (flags_next),
    .phase_count_next  (phase_count_next),
    .saved_count_next  (saved_count_next),
    .safety_count_next (safety_count_next)
  );

  // Sequencer state, updated once per transaction that leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags        <= '0;
      phase_count  <= '0;
      saved_count  <= '0;
      safety_count <= '0;
    end else if (advance) begin
      flags        <= flags_next;
      phase_count  <= phase_count_next;
      saved_count  <= saved_count_next;
      safety_count <= safety_count_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {3'b000, flags_next.safety_mode, flags_next.close_mark,
                       flags_next.open_mark, flags_next.indicator, flags_next.duty,
                       flags_next.direction};
    end
  end

`ifndef SYNTH
  // With both registers full and the output stalled, no event may be taken.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("event accepted while both stages are full and stalled");

  // Every state update produces a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("state update without a result");

  // The phase and safety counters change only when an event is applied.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(phase_count) && $stable(safety_count)))
    else $error("counter changed without an event");

  // The indicator is only ever set, never cleared, outside reset.
  a_indicator_sticky: assert property (@(posedge clk) disable iff (rst)
    flags.indicator |=> flags.indicator)
    else $error("indicator cleared");
`endif

endmodule

`default_nettype wire

/* rtl/dmps_cfg_regs.sv */
// Configuration register file of the door motor phase sequencer.
// Depends on dmps_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module dmps_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_wen,
  input  wire logic [dmps_pkg::CFG_IDX_WIDTH-1:0] cfg_addr,
  input  wire logic [dmps_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
  output dmps_pkg::cfg_t                          cfg
);

  // Register writes; each register keeps only its own width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fast_duty        <= dmps_pkg::FAST_DUTY_RST;
      cfg.slow_duty        <= dmps_pkg::SLOW_DUTY_RST;
      cfg.fast_open_end    <= dmps_pkg::FAST_OPEN_END_RST;
      cfg.slow_open_end    <= dmps_pkg::SLOW_OPEN_END_RST;
      cfg.stop_start       <= dmps_pkg::STOP_START_RST;
      cfg.close_start      <= dmps_pkg::CLOSE_START_RST;
      cfg.slow_close_start <= dmps_pkg::SLOW_CLOSE_START_RST;
      cfg.slow_close_end   <= dmps_pkg::SLOW_CLOSE_END_RST;
    end else if (cfg_wen) begin
      case (dmps_pkg::reg_idx_t'(cfg_addr))
        dmps_pkg::REG_FAST_DUTY:        cfg.fast_duty        <= cfg_wdata[7:0];
        dmps_pkg::REG_SLOW_DUTY:        cfg.slow_duty        <= cfg_wdata[7:0];
        dmps_pkg::REG_FAST_OPEN_END:    cfg.fast_open_end    <= cfg_wdata;
        dmps_pkg::REG_SLOW_OPEN_END:    cfg.slow_open_end    <= cfg_wdata;
        dmps_pkg::REG_STOP_START:       cfg.stop_start       <= cfg_wdata;
        dmps_pkg::REG_CLOSE_START:      cfg.close_start      <= cfg_wdata;
        dmps_pkg::REG_SLOW_CLOSE_START: cfg.slow_close_start <= cfg_wdata;
        dmps_pkg::REG_SLOW_CLOSE_END:   cfg.slow_close_end   <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/dmps_step.sv */
// Next-state logic of the door motor phase sequencer: applies one event to the state.
// Depends on dmps_pkg for cfg_t, flags_t, event_t and the command bytes.
`default_nettype none

module dmps_step #(
  parameter int COUNT_WIDTH = dmps_pkg::COUNT_WIDTH_DEF
) (
  input  wire dmps_pkg::cfg_t    cfg,
  input  wire dmps_pkg::event_t  evt,
  input  wire dmps_pkg::flags_t  flags,
  input  wire logic [COUNT_WIDTH-1:0] phase_count,
  input  wire logic [COUNT_WIDTH-1:0] saved_count,
  input  wire logic [COUNT_WIDTH-1:0] safety_count,
  output dmps_pkg::flags_t       flags_next,
  output logic [COUNT_WIDTH-1:0] phase_count_next,
  output logic [COUNT_WIDTH-1:0] saved_count_next,
  output logic [COUNT_WIDTH-1:0] safety_count_next
);

  // Window bounds widened to the counter width.
  logic [COUNT_WIDTH-1:0] fast_open_end_w;
  logic [COUNT_WIDTH-1:0] slow_open_end_w;
  logic [COUNT_WIDTH-1:0] stop_start_w;
  logic [COUNT_WIDTH-1:0] close_start_w;
  logic [COUNT_WIDTH-1:0] slow_close_start_w;
  logic [COUNT_WIDTH-1:0] slow_close_end_w;
  logic [COUNT_WIDTH-1:0] resume_count;
  logic [COUNT_WIDTH-1:0] tick_count;

  assign fast_open_end_w    = COUNT_WIDTH'(cfg.fast_open_end);
  assign slow_open_end_w    = COUNT_WIDTH'(cfg.slow_open_end);
  assign stop_start_w       = COUNT_WIDTH'(cfg.stop_start);
  assign close_start_w      = COUNT_WIDTH'(cfg.close_start);
  assign slow_close_start_w = COUNT_WIDTH'(cfg.slow_close_start);
  assign slow_close_end_w   = COUNT_WIDTH'(cfg.slow_close_end);

  // Count after a phase tick, and the resume point after a safety return.
  assign tick_count   = phase_count + COUNT_WIDTH'(1);
  assign resume_count = slow_open_end_w + COUNT_WIDTH'(1);

  // Event application: limit levels are latched first, then the event acts.
  always_comb begin
    flags_next        = flags;
    phase_count_next  = phase_count;
    saved_count_next  = saved_count;
    safety_count_next = safety_count;

    if (evt.left_limit_active) begin
      flags_next.left_flag = 1'b1;
    end
    if (evt.right_limit_active) begin
      flags_next.right_flag = 1'b1;
    end

    case (evt.kind)
      dmps_pkg::KIND_PHASE_TICK: begin
        if (flags.run_enable && !flags.safety_mode) begin
          // Phase sequence: open windows first, then the windows gated by the left limit.
          phase_count_next = tick_count;
          if (tick_count <= fast_open_end_w && !flags_next.left_flag) begin
            flags_next.open_mark  = 1'b1;
            flags_next.close_mark = 1'b0;
            flags_next.direction  = 1'b0;
            flags_next.duty       = cfg.fast_duty;
          end else if (tick_count > fast_open_end_w && tick_count <= slow_open_end_w &&
                       !flags_next.left_flag) begin
            flags_next.direction = 1'b0;
            flags_next.duty      = cfg.slow_duty;
          end
          if (flags_next.left_flag) begin
            if (tick_count >= stop_start_w && tick_count < close_start_w) begin
              flags_next.direction = 1'b0;
              flags_next.duty      = 8'd0;
              saved_count_next     = tick_count;
            end else if (tick_count >= close_start_w && tick_count < slow_close_start_w) begin
              flags_next.open_mark  = 1'b0;
              flags_next.close_mark = 1'b1;
              flags_next.direction  = 1'b1;
              flags_next.duty       = cfg.fast_duty;
              saved_count_next      = tick_count;
            end else if (tick_count >= slow_close_start_w &&
                         tick_count <= slow_close_end_w) begin
              flags_next.indicator = 1'b1;
              flags_next.direction = 1'b1;
              flags_next.duty      = cfg.slow_duty;
              saved_count_next     = tick_count;
            end
            flags_next.left_flag = 1'b0;
          end else if (flags_next.right_flag) begin
            // Right limit ends the run.
            flags_next.direction  = 1'b1;
            flags_next.duty       = 8'd0;
            flags_next.run_enable = 1'b0;
            saved_count_next      = '0;
            phase_count_next      = '0;
            flags_next.right_flag = 1'b0;
          end
        end else if (flags.safety_mode) begin
          // Safety: exit if opening; if closing, drive forward to left limit and resume.
          if (flags.open_mark) begin
            flags_next.safety_mode = 1'b0;
          end else if (flags.close_mark) begin
            flags_next.direction       = 1'b0;
            flags_next.duty            = 8'd0;
            flags_next.safety_timer_on = 1'b1;
            if (saved_count != safety_count) begin
              flags_next.duty = cfg.fast_duty;
              if (flags_next.left_flag) begin
                flags_next.duty            = 8'd0;
                phase_count_next           = resume_count;
                flags_next.safety_mode     = 1'b0;
                flags_next.safety_timer_on = 1'b0;
                safety_count_next          = '0;
              end
            end
          end
        end
      end
      dmps_pkg::KIND_SAFETY_TICK: begin
        if (flags.safety_timer_on) begin
          safety_count_next = safety_count + COUNT_WIDTH'(1);
        end
      end
      dmps_pkg::KIND_SAFETY_TRIG: begin
        flags_next.safety_mode = 1'b1;
      end
      dmps_pkg::KIND_COMMAND: begin
        if (evt.rx_byte == dmps_pkg::CMD_RUN) begin
          flags_next.run_enable = 1'b1;
        end else if (evt.rx_byte == dmps_pkg::CMD_HALT) begin
          flags_next.run_enable = 1'b0;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* verif/door_sequence_checker.sv */
// Checker for the door motor phase sequencer: watches the event, result and configuration ports.
// Keeps its own copy of the door state, predicts one status per event and compares field by field.
// Depends on dmps_pkg for the event kinds, command bytes, register indexes and reset values.
module door_sequence_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  input  logic                                s_axis_tready,
  input  logic [dmps_pkg::IN_TDATA_WIDTH-1:0] s_axis_tdata,
  input  logic [dmps_pkg::IN_TUSER_WIDTH-1:0] s_axis_tuser,
  input  logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  input  logic [dmps_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
  input  logic                                cfg_wen,
  input  logic [dmps_pkg::CFG_IDX_WIDTH-1:0]  cfg_addr,
  input  logic [dmps_pkg::CFG_DATA_WIDTH-1:0] cfg_wdata,
  output int                                  errors,
  output int                                  pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import dmps_pkg::*;

  localparam int CW = COUNT_WIDTH_DEF;

  // Status word as it travels on the result tdata, lowest field last.
  typedef struct packed {
    logic [2:0] reserved;
    logic       safety_active;
    logic       closing;
    logic       opening;
    logic       indicator;
    logic [7:0] motor_duty;
    logic       motor_direction;
  } door_status_t;

  // Mirrored configuration.
  logic [7:0] fast_duty, slow_duty;
  logic [9:0] fast_open_end, slow_open_end, stop_start, close_start;
  logic [9:0] slow_close_start, slow_close_end;

  // Mirrored door state.
  logic          run_en, safety_on, open_mk, close_mk, left_seen, right_seen, timer_on;
  logic [CW-1:0] phase_cnt, saved_cnt, safety_cnt;
  logic          dir_q, ind_q;
  logic [7:0]    duty_q;

  door_status_t expected_status[$];
  door_status_t want, got;

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Applies one event to the mirrored state and returns the status that follows.
  task automatic advance_door(input kind_t k, input logic l, input logic r,
                              input logic [7:0] b, output door_status_t st);
    logic [CW-1:0] c;
    logic [CW-1:0] foe, soe, ss, cs, scs, sce;
    foe = CW'(fast_open_end);
    soe = CW'(slow_open_end);
    ss  = CW'(stop_start);
    cs  = CW'(close_start);
    scs = CW'(slow_close_start);
    sce = CW'(slow_close_end);
    if (l) left_seen = 1'b1;
    if (r) right_seen = 1'b1;
    case (k)
      KIND_PHASE_TICK: begin
        if (run_en && !safety_on) begin
          phase_cnt = phase_cnt + CW'(1);
          c = phase_cnt;
          // Travel phases of the opening movement.
          if (c <= foe && !left_seen) begin
            open_mk  = 1'b1;
            close_mk = 1'b0;
            dir_q    = 1'b0;
            duty_q   = fast_duty;
          end else if (c > foe && c <= soe && !left_seen) begin
            dir_q  = 1'b0;
            duty_q = slow_duty;
          end
          // The left limit selects stop, fast close or slow close by count window.
          if (left_seen) begin
            if (c >= ss && c < cs) begin
              dir_q     = 1'b0;
              duty_q    = 8'd0;
              saved_cnt = c;
            end else if (c >= cs && c < scs) begin
              open_mk   = 1'b0;
              close_mk  = 1'b1;
              dir_q     = 1'b1;
              duty_q    = fast_duty;
              saved_cnt = c;
            end else if (c >= scs && c <= sce) begin
              ind_q     = 1'b1;
              dir_q     = 1'b1;
              duty_q    = slow_duty;
              saved_cnt = c;
            end
            left_seen = 1'b0;
          end else if (right_seen) begin
            dir_q      = 1'b1;
            duty_q     = 8'd0;
            run_en     = 1'b0;
            saved_cnt  = '0;
            phase_cnt  = '0;
            right_seen = 1'b0;
          end
        end else if (safety_on) begin
          // Safety return: open movement just leaves safety, closing drives back.
          if (open_mk) begin
            safety_on = 1'b0;
          end else if (close_mk) begin
            dir_q    = 1'b0;
            duty_q   = 8'd0;
            timer_on = 1'b1;
            if (saved_cnt != safety_cnt) begin
              duty_q = fast_duty;
              if (left_seen) begin
                duty_q     = 8'd0;
                phase_cnt  = soe + CW'(1);
                safety_on  = 1'b0;
                timer_on   = 1'b0;
                safety_cnt = '0;
              end
            end
          end
        end
      end
      KIND_SAFETY_TICK: begin
        if (timer_on) safety_cnt = safety_cnt + CW'(1);
      end
      KIND_SAFETY_TRIG: begin
        safety_on = 1'b1;
      end
      default: begin
        if (b == CMD_RUN) run_en = 1'b1;
        else if (b == CMD_HALT) run_en = 1'b0;
      end
    endcase
    st                 = '0;
    st.motor_direction = dir_q;
    st.motor_duty      = duty_q;
    st.indicator       = ind_q;
    st.opening         = open_mk;
    st.closing         = close_mk;
    st.safety_active   = safety_on;
  endtask

  task automatic compare_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      errors++;
    end
  endtask

  // Results are checked before new events are queued, so a stray result never
  // matches the expectation of an event taken on the same edge.
  always @(posedge clk) begin
    if (rst) begin
      fast_duty        = FAST_DUTY_RST;
      slow_duty        = SLOW_DUTY_RST;
      fast_open_end    = FAST_OPEN_END_RST;
      slow_open_end    = SLOW_OPEN_END_RST;
      stop_start       = STOP_START_RST;
      close_start      = CLOSE_START_RST;
      slow_close_start = SLOW_CLOSE_START_RST;
      slow_close_end   = SLOW_CLOSE_END_RST;
      {run_en, safety_on, open_mk, close_mk, left_seen, right_seen, timer_on} = '0;
      phase_cnt  = '0;
      saved_cnt  = '0;
      safety_cnt = '0;
      dir_q      = 1'b0;
      duty_q     = 8'd0;
      ind_q      = 1'b0;
      expected_status.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = door_status_t'(m_axis_tdata);
        if (expected_status.size() == 0) begin
          $error("result transaction with no event waiting, tdata %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_status.pop_front();
          compare_field("motor_direction", 8'(want.motor_direction),
                        8'(got.motor_direction));
          compare_field("motor_duty", want.motor_duty, got.motor_duty);
          compare_field("indicator", 8'(want.indicator), 8'(got.indicator));
          compare_field("opening", 8'(want.opening), 8'(got.opening));
          compare_field("closing", 8'(want.closing), 8'(got.closing));
          compare_field("safety_active", 8'(want.safety_active), 8'(got.safety_active));
          compare_field("reserved", 8'(want.reserved), 8'(got.reserved));
        end
      end
      if (cfg_wen) begin
        case (reg_idx_t'(cfg_addr))
          REG_FAST_DUTY:        fast_duty        = cfg_wdata[7:0];
          REG_SLOW_DUTY:        slow_duty        = cfg_wdata[7:0];
          REG_FAST_OPEN_END:    fast_open_end    = cfg_wdata;
          REG_SLOW_OPEN_END:    slow_open_end    = cfg_wdata;
          REG_STOP_START:       stop_start       = cfg_wdata;
          REG_CLOSE_START:      close_start      = cfg_wdata;
          REG_SLOW_CLOSE_START: slow_close_start = cfg_wdata;
          default:              slow_close_end   = cfg_wdata;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_door(kind_t'(s_axis_tuser), s_axis_tdata[0], s_axis_tdata[1],
                     s_axis_tdata[9:2], want);
        expected_status.push_back(want);
      end
    end
    pending = expected_status.size();
  end

endmodule

/* verif/tb.sv */
// Top of the door motor phase sequencer testbench: clock, reset, event stimulus and verdict.
// Instantiates door_motor_phase_sequencer and door_sequence_checker; uses dmps_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dmps_pkg::*;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_WIDTH-1:0]  s_axis_tuser = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] m_axis_tdata;
  logic                       cfg_wen = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]   cfg_addr = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_wdata = '0;

  int errors;
  int pending;
  int tx_gap_pct = 0;
  int rx_stall_pct = 0;
  int items_sent = 0;
  // Copy of the register setting that load_config writes; also aims the sensor levels and safety triggers.
  int door_cfg[8];

  door_motor_phase_sequencer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  door_sequence_checker watch (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wen       (cfg_wen),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .errors        (errors),
    .pending       (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side backpressure.
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Sends one event; tvalid stays high afterwards unless the next event idles first.
  task automatic send_event(input kind_t k, input logic l, input logic r, input logic [7:0] b);
    if ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_gap_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= {6'b000000, b, r, l};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Holds off the sender until every expected status has come back.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_config();
    for (int i = 0; i < 8; i++) begin
      cfg_wen   <= 1'b1;
      cfg_addr  <= reg_idx_t'(i);
      cfg_wdata <= CFG_DATA_WIDTH'(door_cfg[i]);
      @(negedge clk);
    end
    cfg_wen <= 1'b0;
  endtask

  // Chooses a register setting: ordered small windows, one of the extreme sets, or out-of-order windows.
  task automatic pick_setting(input int stage);
    case (stage)
      1: begin
        door_cfg[REG_FAST_DUTY]        = 255;
        door_cfg[REG_SLOW_DUTY]        = 0;
        door_cfg[REG_FAST_OPEN_END]    = 0;
        door_cfg[REG_SLOW_OPEN_END]    = 0;
        door_cfg[REG_STOP_START]       = 0;
        door_cfg[REG_CLOSE_START]      = 4;
        door_cfg[REG_SLOW_CLOSE_START] = 7;
        door_cfg[REG_SLOW_CLOSE_END]   = 1023;
      end
      3: begin
        // Stop and fast-close windows are out of order and never match.
        door_cfg[REG_FAST_DUTY]        = $urandom_range(255);
        door_cfg[REG_SLOW_DUTY]        = $urandom_range(255);
        door_cfg[REG_FAST_OPEN_END]    = 2;
        door_cfg[REG_SLOW_OPEN_END]    = 5;
        door_cfg[REG_STOP_START]       = 9;
        door_cfg[REG_CLOSE_START]      = 0;
        door_cfg[REG_SLOW_CLOSE_START] = 0;
        door_cfg[REG_SLOW_CLOSE_END]   = 14;
      end
      5: begin
        door_cfg[REG_FAST_DUTY]        = 0;
        door_cfg[REG_SLOW_DUTY]        = 255;
        door_cfg[REG_FAST_OPEN_END]    = 1023;
        door_cfg[REG_SLOW_OPEN_END]    = 1023;
        door_cfg[REG_STOP_START]       = 1023;
        door_cfg[REG_CLOSE_START]      = 1023;
        door_cfg[REG_SLOW_CLOSE_START] = 1023;
        door_cfg[REG_SLOW_CLOSE_END]   = 0;
      end
      default: begin
        door_cfg[REG_FAST_DUTY]        = $urandom_range(255);
        door_cfg[REG_SLOW_DUTY]        = $urandom_range(255);
        door_cfg[REG_FAST_OPEN_END]    = $urandom_range(6, 1);
        door_cfg[REG_SLOW_OPEN_END]    = door_cfg[REG_FAST_OPEN_END] + $urandom_range(4);
        door_cfg[REG_STOP_START]       = $urandom_range(door_cfg[REG_SLOW_OPEN_END] + 2,
                                                        door_cfg[REG_FAST_OPEN_END]);
        door_cfg[REG_CLOSE_START]      = door_cfg[REG_SLOW_OPEN_END] + $urandom_range(5, 1);
        door_cfg[REG_SLOW_CLOSE_START] = door_cfg[REG_CLOSE_START] + $urandom_range(5, 1);
        door_cfg[REG_SLOW_CLOSE_END]   = door_cfg[REG_SLOW_CLOSE_START] + $urandom_range(5);
      end
    endcase
    load_config();
  endtask

  // Safety trigger followed by a return: timer ticks, then two tries at the left limit,
  // the second one after a timer tick in case the counts were equal on the first.
  task automatic safety_return(input int timer_ticks);
    send_event(KIND_SAFETY_TRIG, 1'b0, 1'b0, 8'($urandom_range(255)));
    send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'($urandom_range(255)));
    repeat (timer_ticks) begin
      send_event(KIND_SAFETY_TICK, 1'b0, 1'b0, 8'($urandom_range(255)));
      if (tx_gap_pct != 0 && $urandom_range(1))
        send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'($urandom_range(255)));
    end
    repeat (2) begin
      send_event(KIND_PHASE_TICK, 1'b1, 1'b0, 8'($urandom_range(255)));
      send_event(KIND_SAFETY_TICK, 1'b0, 1'b0, 8'($urandom_range(255)));
    end
  endtask

  // One open/close run with the left limit aimed at the configured windows.
  task automatic run_door_cycle();
    int   span;
    logic l;
    span = 0;
    for (int i = REG_FAST_OPEN_END; i <= REG_SLOW_CLOSE_END; i++)
      if (door_cfg[i] > span) span = door_cfg[i];
    if (span > 40) span = 40;
    send_event(KIND_COMMAND, 1'b0, 1'b0, CMD_RUN);
    for (int t = 1; t <= span + 2; t++) begin
      if (t >= door_cfg[REG_STOP_START] && t <= door_cfg[REG_SLOW_CLOSE_END])
        l = ($urandom_range(99) < 85);
      else
        l = ($urandom_range(99) < 4);
      send_event(KIND_PHASE_TICK, l, 1'b0, 8'($urandom_range(255)));
      if ($urandom_range(99) < 8)
        send_event(KIND_SAFETY_TICK, 1'b0, 1'b0, 8'($urandom_range(255)));
      if (t >= door_cfg[REG_CLOSE_START] && $urandom_range(99) < 6) begin
        safety_return($urandom_range(12));
      end else if (t <= door_cfg[REG_SLOW_OPEN_END] && $urandom_range(99) < 3) begin
        send_event(KIND_SAFETY_TRIG, 1'b0, 1'b0, 8'($urandom_range(255)));
        send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'($urandom_range(255)));
      end
    end
    send_event(KIND_PHASE_TICK, 1'b0, 1'b1, 8'($urandom_range(255)));
  endtask

  // Unstructured event with any kind, sensor levels and byte.
  task automatic send_noise();
    kind_t      k;
    logic [7:0] b;
    k = kind_t'($urandom_range(3));
    case ($urandom_range(3))
      0:       b = CMD_RUN;
      1:       b = CMD_HALT;
      default: b = 8'($urandom_range(255));
    endcase
    send_event(k, $urandom_range(99) < 10, $urandom_range(99) < 8, b);
  endtask

  initial begin
    #12_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int budget;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    door_cfg[REG_FAST_DUTY]        = FAST_DUTY_RST;
    door_cfg[REG_SLOW_DUTY]        = SLOW_DUTY_RST;
    door_cfg[REG_FAST_OPEN_END]    = FAST_OPEN_END_RST;
    door_cfg[REG_SLOW_OPEN_END]    = SLOW_OPEN_END_RST;
    door_cfg[REG_STOP_START]       = STOP_START_RST;
    door_cfg[REG_CLOSE_START]      = CLOSE_START_RST;
    door_cfg[REG_SLOW_CLOSE_START] = SLOW_CLOSE_START_RST;
    door_cfg[REG_SLOW_CLOSE_END]   = SLOW_CLOSE_END_RST;
    tx_gap_pct   = 16;
    rx_stall_pct = 50;
    @(negedge clk);

    // Directed events on the reset setting. A safety trigger is only sent once a
    // movement mark is set, since with no mark safety mode can never be left.
    send_event(KIND_SAFETY_TICK, 1'b0, 1'b0, 8'h00);
    send_event(KIND_COMMAND, 1'b0, 1'b0, 8'hFF);
    send_event(KIND_COMMAND, 1'b0, 1'b0, 8'h00);
    send_event(KIND_COMMAND, 1'b0, 1'b0, CMD_HALT);
    send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'h00);
    send_event(KIND_COMMAND, 1'b0, 1'b0, CMD_RUN);
    send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'hFF);
    send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'h00);
    send_event(KIND_SAFETY_TRIG, 1'b0, 1'b0, 8'h00);
    send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'h00);
    send_event(KIND_PHASE_TICK, 1'b1, 1'b0, 8'h00);
    send_event(KIND_PHASE_TICK, 1'b1, 1'b1, 8'h00);
    send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'h00);
    send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'h00);
    send_event(KIND_COMMAND, 1'b0, 1'b0, 8'h55);
    send_event(KIND_COMMAND, 1'b0, 1'b0, 8'hAA);
    send_event(KIND_COMMAND, 1'b0, 1'b0, CMD_RUN);
    send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'h00);

    // Random stages: receiver stalls most, then sender idles most, then neither; two settings each.
    for (int stage = 0; stage < 6; stage++) begin
      tx_gap_pct   = (stage < 2) ? 16 : (stage < 4) ? 50 : 0;
      rx_stall_pct = (stage < 2) ? 50 : (stage < 4) ? 16 : 0;
      settle();
      pick_setting(stage);
      budget = items_sent + 225;
      while (items_sent < budget) begin
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(5, 1)) send_noise();
        end else begin
          run_door_cycle();
        end
        if ($urandom_range(99) < 3) settle();
      end
    end

    // Leave safety mode and clear latched limits before the closing walk.
    safety_return(1);
    repeat (3) begin
      send_event(KIND_COMMAND, 1'b0, 1'b0, CMD_RUN);
      send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'($urandom_range(255)));
    end

    // Walk into fast closing, trigger, then tick the safety timer a while.
    settle();
    pick_setting(0);
    door_cfg[REG_FAST_OPEN_END]    = 1;
    door_cfg[REG_SLOW_OPEN_END]    = 2;
    door_cfg[REG_STOP_START]       = 3;
    door_cfg[REG_CLOSE_START]      = 4;
    door_cfg[REG_SLOW_CLOSE_START] = 6;
    door_cfg[REG_SLOW_CLOSE_END]   = 8;
    load_config();
    send_event(KIND_PHASE_TICK, 1'b0, 1'b1, 8'h00);
    send_event(KIND_COMMAND, 1'b0, 1'b0, CMD_RUN);
    send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'h00);
    send_event(KIND_PHASE_TICK, 1'b0, 1'b0, 8'h00);
    send_event(KIND_PHASE_TICK, 1'b1, 1'b0, 8'h00);
    send_event(KIND_PHASE_TICK, 1'b1, 1'b0, 8'h00);
    safety_return(20);

    settle();
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
